// ===== rtl/lbp_pkg.sv =====
// Shared constants and types for the 3x3 LBP pixel stream block.
// No dependencies; used by lbp_3x3_pixel_stream and lbp_core in rtl/.
`timescale 1ns / 1ps
`default_nettype none
package lbp_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int PIX_W        = 8;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WCFG_W       = 11;
  localparam int HCFG_W       = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int LINE_W       = 2 * PIX_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd128;
  localparam logic [HCFG_W-1:0] HEIGHT_RESET = 13'd128;
  localparam logic [WCFG_W-1:0] MIN_DIM_W    = 11'd3;
  localparam logic [HCFG_W-1:0] MIN_DIM_H    = 13'd3;
  localparam logic [WCFG_W-1:0] MAX_WIDTH_V  = WCFG_W'(MAX_WIDTH);
  localparam logic [HCFG_W-1:0] MAX_HEIGHT_V = HCFG_W'(MAX_HEIGHT);

  // column of pixels handed to the window for one beat
  typedef struct packed {
    logic [PIX_W-1:0] two_above;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] pixel;
  } lbp_nbr_t;

endpackage
`default_nettype wire

// ===== rtl/lbp_3x3_pixel_stream.sv =====
// Top level: config registers, raster counters, input stage and result register.
// Depends on lbp_pkg, lbp_line_ram, lbp_core.
//
//   channel   signals                         dir   beat
//   in        in_valid in_stall pixel         in    one gray pixel, raster order
//   out       out_valid out_stall lbp_code    out   one code per interior centre
//             frame_last
//   cfg       cfg_we cfg_index cfg_data       in    register write, no handshake
//
// One pixel per cycle unless stalled; codes pass input stage and result register.
// The line RAM read at the column address on accept sets the input stage depth.
// Reset clears counters, window and valids; config returns to 128 x 128.
// out_stall backs up through the result register into in_stall with no bubble.
`timescale 1ns / 1ps
`default_nettype none
module lbp_3x3_pixel_stream (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [lbp_pkg::PIX_W-1:0]         pixel,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [lbp_pkg::PIX_W-1:0]         lbp_code,
  output logic                                   frame_last,
  input  wire logic                              cfg_we,
  input  wire logic [lbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lbp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [lbp_pkg::WCFG_W-1:0] image_width;
  logic [lbp_pkg::HCFG_W-1:0] image_height;
  logic [lbp_pkg::WCFG_W-1:0] w_eff;
  logic [lbp_pkg::HCFG_W-1:0] h_eff;
  logic [lbp_pkg::COL_W-1:0]  col_last;
  logic [lbp_pkg::ROW_W-1:0]  row_last;

  logic [lbp_pkg::COL_W-1:0]  col;
  logic [lbp_pkg::ROW_W-1:0]  row;
  logic                       is_last_col;
  logic                       is_last_row;
  logic                       accept;

  logic                       s1_valid;
  logic [lbp_pkg::PIX_W-1:0]  s1_pixel;
  logic [lbp_pkg::COL_W-1:0]  s1_col;
  logic                       s1_emit;
  logic                       s1_last;
  logic                       s1_advance;

  logic [lbp_pkg::LINE_W-1:0] line_rdata;
  lbp_pkg::lbp_nbr_t          nbr;
  logic [lbp_pkg::PIX_W-1:0]  code;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lbp_pkg::WIDTH_RESET;
      image_height <= lbp_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbp_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[lbp_pkg::WCFG_W-1:0];
        lbp_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = image_width;
    if (image_width < lbp_pkg::MIN_DIM_W) w_eff = lbp_pkg::MIN_DIM_W;
    if (image_width > lbp_pkg::MAX_WIDTH_V) w_eff = lbp_pkg::MAX_WIDTH_V;
    h_eff = image_height;
    if (image_height < lbp_pkg::MIN_DIM_H) h_eff = lbp_pkg::MIN_DIM_H;
    if (image_height > lbp_pkg::MAX_HEIGHT_V) h_eff = lbp_pkg::MAX_HEIGHT_V;
  end

  assign col_last    = lbp_pkg::COL_W'(w_eff - lbp_pkg::WCFG_W'(1));
  assign row_last    = lbp_pkg::ROW_W'(h_eff - lbp_pkg::HCFG_W'(1));
  assign is_last_col = col >= col_last;
  assign is_last_row = row >= row_last;

  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign accept     = in_valid && !in_stall;

  // raster position of the next pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (is_last_col) begin
        col <= '0;
        row <= is_last_row ? '0 : row + lbp_pkg::ROW_W'(1);
      end else begin
        col <= col + lbp_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel;
      s1_col   <= col;
      s1_emit  <= (row >= lbp_pkg::ROW_W'(2)) && (col >= lbp_pkg::COL_W'(2));
      s1_last  <= is_last_col && is_last_row;
    end
  end

  lbp_line_ram #(
    .DEPTH  (lbp_pkg::MAX_WIDTH),
    .DATA_W (lbp_pkg::LINE_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_advance),
    .waddr (s1_col),
    .wdata ({nbr.above, s1_pixel}),
    .re    (accept),
    .raddr (col),
    .rdata (line_rdata)
  );

  assign nbr.two_above = line_rdata[lbp_pkg::LINE_W-1:lbp_pkg::PIX_W];
  assign nbr.above     = line_rdata[lbp_pkg::PIX_W-1:0];
  assign nbr.pixel     = s1_pixel;

  lbp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_advance),
    .nbr     (nbr),
    .code    (code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_emit) begin
      lbp_code   <= code;
      frame_last <= s1_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lbp_line_ram.sv =====
// Generic single-write, single-read RAM with registered, enabled read.
// Holds both line buffers side by side; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lbp_line_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lbp_core.sv =====
// 3x3 window shift registers and LBP code compare logic.
// Depends on lbp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbp_core (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    advance,
  input  wire lbp_pkg::lbp_nbr_t       nbr,
  output logic [lbp_pkg::PIX_W-1:0]    code
);

  // 0..2: column c-2 (top, mid, bottom); 3..5: column c-1
  logic [lbp_pkg::PIX_W-1:0] win [6];
  logic [lbp_pkg::PIX_W-1:0] ctr;

  assign ctr = win[4];

  always_comb begin
    code[7] = win[0]        >= ctr;
    code[6] = win[3]        >= ctr;
    code[5] = nbr.two_above >= ctr;
    code[4] = nbr.above     >= ctr;
    code[3] = nbr.pixel     >= ctr;
    code[2] = win[5]        >= ctr;
    code[1] = win[2]        >= ctr;
    code[0] = win[1]        >= ctr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (advance) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= nbr.two_above;
      win[4] <= nbr.above;
      win[5] <= nbr.pixel;
    end
  end

endmodule
`default_nettype wire
